>>> design/spl_pkg.sv
// spl_pkg: shared widths, register map and reset values for the stereo peak limiter.
// Used by the channel interfaces and by the top level; depends on nothing.

package spl_pkg;

	// Default sample width of the input channel
	localparam int SAMPLE_BITS_DEF = 24;

	// Field widths fixed by the sample formats
	localparam int GAIN_W  = 18;
	localparam int OUT_W   = 22;
	localparam int RED_W   = 17;
	localparam int HC_W    = 23;
	localparam int LC_W    = 21;
	localparam int COEF_W  = 16;
	localparam int ENV_W   = 24;

	// APB register file
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	typedef enum logic [1:0] {
		REG_HARD_CEIL  = 2'd0,
		REG_LIMIT_CEIL = 2'd1,
		REG_RELEASE    = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

	// Reset values of the registers
	localparam logic [HC_W-1:0]   HARD_CEIL_RST  = 23'd4194304;
	localparam logic [LC_W-1:0]   LIMIT_CEIL_RST = 21'd1027604;
	localparam logic [COEF_W-1:0] RELEASE_RST    = 16'd65518;

	// Fixed-point constants
	localparam logic [HC_W-1:0]  ONE_Q20   = 23'd1048576;
	localparam logic [RED_W-1:0] UNITY_Q16 = 17'd65536;
	localparam int               ROUND_Q16 = 32768;
	localparam int               DIV_STEPS = 16;

endpackage

>>> design/spl_if.sv
// spl_if: valid/ready channel interfaces for the stereo peak limiter.
// Input channel carries one stereo pair and gain; output channel one limited pair.
// Depends on spl_pkg.

interface spl_in_if #(
	parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic signed [SAMPLE_BITS-1:0]   left_in;
	logic signed [SAMPLE_BITS-1:0]   right_in;
	logic [spl_pkg::GAIN_W-1:0]      gain;

	modport source (output valid, left_in, right_in, gain, input ready);
	modport sink   (input valid, left_in, right_in, gain, output ready);
endinterface

interface spl_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [spl_pkg::OUT_W-1:0] left_out;
	logic signed [spl_pkg::OUT_W-1:0] right_out;
	logic [spl_pkg::RED_W-1:0]       reduction;
	logic                            hard_clipped;
	logic                            limited;

	modport source (output valid, left_out, right_out, reduction, hard_clipped, limited,
		input ready);
	modport sink   (input valid, left_out, right_out, reduction, hard_clipped, limited,
		output ready);
endinterface

>>> design/stereo_peak_limiter.sv
// stereo_peak_limiter: gain, hard clamp, peak envelope, ceiling limiter and final clip.
// One shared multiplier and a restoring divider step under a small sequencer.
// Depends on spl_pkg and the channel interfaces in spl_if.sv.
//
// Usage:
//  - in_ch takes one word: a signed stereo pair (SAMPLE_BITS each, Q4.20) and an
//    unsigned Q2.16 gain. in_ch.ready is high only while the sequencer is idle.
//  - out_ch delivers one word per input: both limited channels (Q2.20, within
//    plus or minus one), the Q1.16 reduction and the hard_clipped / limited flags.
//  - APB port: hard_ceiling at 0x0, limit_ceiling at 0x4, release_coeff at 0x8.
//    Write only while idle; pready is tied high, reads return the register.
//  - Sequence: gain products and rounding, peak, envelope attack or release (release
//    product and sum), limit check, the 16-step reduction division only when the
//    limiter engages, scaling products and clip, then emit to out_ch.
//    One multiplier serves the gain products, the envelope release and the
//    reduction scaling, one product per cycle.
//  - A new pair is accepted only once the sequencer is back in idle; it may be
//    accepted while the previous result still waits in the output register.
//  - If out_ch stalls, the finished word waits in the last step until the
//    output register is free; nothing is dropped.
//  - Reset clears the envelope, the sequencer and out_ch.valid and loads the
//    register defaults; no clearing pass is needed.

module stereo_peak_limiter #(
	parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	spl_in_if.sink                       in_ch,
	spl_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [spl_pkg::ADDR_W-1:0]   paddr,
	input  logic [spl_pkg::DATA_W-1:0]   pwdata,
	output logic [spl_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	// Multiplier operand width: widest of sample magnitude and envelope
	localparam int MW = (SAMPLE_BITS > spl_pkg::ENV_W) ? SAMPLE_BITS : spl_pkg::ENV_W;
	localparam int PW = MW + spl_pkg::GAIN_W;
	localparam int HW = spl_pkg::HC_W;
	localparam int CW = $clog2(spl_pkg::DIV_STEPS);
	// Full scale as a signed output value
	localparam logic signed [spl_pkg::OUT_W-1:0] FULL_S = spl_pkg::OUT_W'(spl_pkg::ONE_Q20);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_L, S_MUL_R, S_RND_R, S_PEAK, S_DIFF, S_REL, S_RELADD,
		S_LIMCHK, S_DIV, S_SCL_L, S_SCL_R, S_CLIP_R, S_EMIT
	} state_t;

	state_t                         state_q;
	logic [spl_pkg::HC_W-1:0]       hard_ceil_q;
	logic [spl_pkg::LC_W-1:0]       limit_ceil_q;
	logic [spl_pkg::COEF_W-1:0]     release_q;

	logic [SAMPLE_BITS-1:0]         mag_l_q, mag_r_q;
	logic                           neg_l_q, neg_r_q;
	logic [spl_pkg::GAIN_W-1:0]     gain_q;
	logic [HW-1:0]                  ml_q, mr_q, peak_q;
	logic [spl_pkg::ENV_W-1:0]      env_q, diff_q, rem_q;
	logic [spl_pkg::RED_W-1:0]      red_q;
	logic [CW-1:0]                  cnt_q;
	logic                           clip_q, lim_q;
	logic [PW-1:0]                  prod_q;

	logic                           out_valid_q;
	logic signed [spl_pkg::OUT_W-1:0] left_out_q, right_out_q;
	logic [spl_pkg::RED_W-1:0]      red_out_q;
	logic                           clip_out_q, lim_out_q;

	logic [MW-1:0]                  mul_a;
	logic [spl_pkg::GAIN_W-1:0]     mul_b;
	logic [PW-1:0]                  mul_p;
	logic [PW:0]                    rnd_sum;
	logic [PW-16:0]                 rnd_mag;
	logic                           rnd_over;
	logic [HW-1:0]                  rnd_clamped;
	logic [PW-17:0]                 scl_mag;
	logic                           scl_over;
	logic [HW-1:0]                  scl_clipped;
	logic [PW-17:0]                 rel_sum;
	logic [spl_pkg::ENV_W:0]        rem2, rem_sub;
	logic                           div_ge;
	logic                           in_acc, cfg_wr;
	logic [SAMPLE_BITS-1:0]         raw_l, raw_r;
	logic                           out_free;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	// Register file write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hard_ceil_q  <= spl_pkg::HARD_CEIL_RST;
			limit_ceil_q <= spl_pkg::LIMIT_CEIL_RST;
			release_q    <= spl_pkg::RELEASE_RST;
		end else if (cfg_wr) begin
			case (spl_pkg::reg_idx_t'(paddr[3:2]))
				spl_pkg::REG_HARD_CEIL:  hard_ceil_q  <= pwdata[spl_pkg::HC_W-1:0];
				spl_pkg::REG_LIMIT_CEIL: limit_ceil_q <= pwdata[spl_pkg::LC_W-1:0];
				spl_pkg::REG_RELEASE:    release_q    <= pwdata[spl_pkg::COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (spl_pkg::reg_idx_t'(paddr[3:2]))
			spl_pkg::REG_HARD_CEIL:  prdata = spl_pkg::DATA_W'(hard_ceil_q);
			spl_pkg::REG_LIMIT_CEIL: prdata = spl_pkg::DATA_W'(limit_ceil_q);
			spl_pkg::REG_RELEASE:    prdata = spl_pkg::DATA_W'(release_q);
			default:                 prdata = '0;
		endcase
	end

	// Route operands to the shared multiplier
	always_comb begin
		case (state_q)
			S_MUL_L: begin
				mul_a = MW'(mag_l_q);
				mul_b = gain_q;
			end
			S_MUL_R: begin
				mul_a = MW'(mag_r_q);
				mul_b = gain_q;
			end
			S_REL: begin
				mul_a = MW'(diff_q);
				mul_b = spl_pkg::GAIN_W'(release_q);
			end
			S_SCL_L: begin
				mul_a = MW'(ml_q);
				mul_b = spl_pkg::GAIN_W'(red_q);
			end
			S_SCL_R: begin
				mul_a = MW'(mr_q);
				mul_b = spl_pkg::GAIN_W'(red_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// Round the gain product to nearest and clamp to the hard ceiling
	assign rnd_sum     = {1'b0, prod_q} + (PW+1)'(spl_pkg::ROUND_Q16);
	assign rnd_mag     = rnd_sum[PW:16];
	assign rnd_over    = rnd_mag > (PW-15)'(hard_ceil_q);
	assign rnd_clamped = rnd_over ? hard_ceil_q : rnd_mag[HW-1:0];

	// Truncate the reduction product and clip to one
	assign scl_mag     = prod_q[PW-1:16];
	assign scl_over    = scl_mag > (PW-16)'(spl_pkg::ONE_Q20);
	assign scl_clipped = scl_over ? spl_pkg::ONE_Q20 : scl_mag[HW-1:0];

	// Release: decay toward the peak
	assign rel_sum = (PW-16)'(peak_q) + prod_q[PW-1:16];

	// One restoring division step for the reduction quotient
	assign rem2    = {rem_q, 1'b0};
	assign div_ge  = rem2 >= {1'b0, env_q};
	assign rem_sub = rem2 - {1'b0, env_q};

	// Split input samples into sign and magnitude
	assign raw_l = in_ch.left_in;
	assign raw_r = in_ch.right_in;

	// Sequencer, datapath registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mag_l_q     <= '0;
			mag_r_q     <= '0;
			neg_l_q     <= 1'b0;
			neg_r_q     <= 1'b0;
			gain_q      <= '0;
			ml_q        <= '0;
			mr_q        <= '0;
			peak_q      <= '0;
			env_q       <= '0;
			diff_q      <= '0;
			rem_q       <= '0;
			red_q       <= spl_pkg::UNITY_Q16;
			cnt_q       <= '0;
			clip_q      <= 1'b0;
			lim_q       <= 1'b0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			left_out_q  <= '0;
			right_out_q <= '0;
			red_out_q   <= spl_pkg::UNITY_Q16;
			clip_out_q  <= 1'b0;
			lim_out_q   <= 1'b0;
		end else begin
			prod_q <= mul_p;
			// load a new output word, else drop the old one once taken
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						neg_l_q <= raw_l[SAMPLE_BITS-1];
						neg_r_q <= raw_r[SAMPLE_BITS-1];
						mag_l_q <= raw_l[SAMPLE_BITS-1] ? (~raw_l + 1'b1) : raw_l;
						mag_r_q <= raw_r[SAMPLE_BITS-1] ? (~raw_r + 1'b1) : raw_r;
						gain_q  <= in_ch.gain;
						clip_q  <= 1'b0;
						lim_q   <= 1'b0;
						state_q <= S_MUL_L;
					end
				end
				S_MUL_L: begin
					state_q <= S_MUL_R;
				end
				S_MUL_R: begin
					ml_q    <= rnd_clamped;
					clip_q  <= clip_q | rnd_over;
					state_q <= S_RND_R;
				end
				S_RND_R: begin
					mr_q    <= rnd_clamped;
					clip_q  <= clip_q | rnd_over;
					state_q <= S_PEAK;
				end
				S_PEAK: begin
					peak_q  <= (ml_q > mr_q) ? ml_q : mr_q;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					// instant attack, else start the release product
					if (spl_pkg::ENV_W'(peak_q) > env_q) begin
						env_q   <= spl_pkg::ENV_W'(peak_q);
						state_q <= S_LIMCHK;
					end else begin
						diff_q  <= env_q - spl_pkg::ENV_W'(peak_q);
						state_q <= S_REL;
					end
				end
				S_REL: begin
					state_q <= S_RELADD;
				end
				S_RELADD: begin
					env_q   <= rel_sum[spl_pkg::ENV_W-1:0];
					state_q <= S_LIMCHK;
				end
				S_LIMCHK: begin
					if (env_q > spl_pkg::ENV_W'(limit_ceil_q)) begin
						rem_q   <= spl_pkg::ENV_W'(limit_ceil_q);
						red_q   <= '0;
						cnt_q   <= '0;
						lim_q   <= 1'b1;
						state_q <= S_DIV;
					end else begin
						red_q   <= spl_pkg::UNITY_Q16;
						state_q <= S_SCL_L;
					end
				end
				S_DIV: begin
					rem_q <= div_ge ? rem_sub[spl_pkg::ENV_W-1:0] : rem2[spl_pkg::ENV_W-1:0];
					red_q <= {red_q[spl_pkg::RED_W-2:0], div_ge};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(spl_pkg::DIV_STEPS - 1)) begin
						state_q <= S_SCL_L;
					end
				end
				S_SCL_L: begin
					state_q <= S_SCL_R;
				end
				S_SCL_R: begin
					ml_q    <= scl_clipped;
					lim_q   <= lim_q | scl_over;
					state_q <= S_CLIP_R;
				end
				S_CLIP_R: begin
					mr_q    <= scl_clipped;
					lim_q   <= lim_q | scl_over;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (out_free) begin
						left_out_q  <= neg_l_q ? (spl_pkg::OUT_W'(0) - spl_pkg::OUT_W'(ml_q))
							: spl_pkg::OUT_W'(ml_q);
						right_out_q <= neg_r_q ? (spl_pkg::OUT_W'(0) - spl_pkg::OUT_W'(mr_q))
							: spl_pkg::OUT_W'(mr_q);
						red_out_q   <= red_q;
						clip_out_q  <= clip_q;
						lim_out_q   <= lim_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.left_out     = left_out_q;
	assign out_ch.right_out    = right_out_q;
	assign out_ch.reduction    = red_out_q;
	assign out_ch.hard_clipped = clip_out_q;
	assign out_ch.limited      = lim_out_q;

	// Envelope never grows past the largest clamped magnitude
	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q < (spl_pkg::ENV_W'(1) << spl_pkg::HC_W))
		else $error("peak envelope out of range");

	// Any reduction below unity comes with the limited flag
	a_red_lim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (red_out_q != spl_pkg::UNITY_Q16) |-> lim_out_q)
		else $error("reduction applied without limited flag");

	// Reduction never exceeds unity
	a_red_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> red_out_q <= spl_pkg::UNITY_Q16)
		else $error("reduction above unity");

	// Limited outputs stay within plus or minus one
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (left_out_q <= FULL_S) && (left_out_q >= -FULL_S)
			&& (right_out_q <= FULL_S) && (right_out_q >= -FULL_S))
		else $error("output sample beyond full scale");

	// An item entering the sequencer reaches the multiplier next cycle
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == S_MUL_L)
		else $error("accepted word did not start the sequence");

endmodule
